### design/pipid_pkg.sv
// ----------------------------------------------------------------------------
// pipid_pkg
// Shared types and constants of the PID regulator: register indexes,
// command and mode codes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package pipid_pkg;

  // fixed field widths
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 20;
  localparam int INTEG_W        = 21;
  localparam int DRIVE_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;
  localparam int GAIN_FRAC_BITS = 8;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_KP    = 3'd1,
    REG_KI    = 3'd2,
    REG_KD    = 3'd3,
    REG_LIMIT = 3'd4
  } reg_index_t;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } pid_mode_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_CLEAR  = 1'b1
  } command_t;

  // reset values of the registers
  localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd23040;
  localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd691;
  localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd12800;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1500;

  // saturation bounds of the output
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7fff_ffff;
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

  typedef struct packed {
    pid_mode_t            mode;
    logic [GAIN_W-1:0]    kp;
    logic [GAIN_W-1:0]    ki;
    logic [GAIN_W-1:0]    kd;
    logic [LIMIT_W-1:0]   limit;
  } pid_cfg_t;

endpackage

### design/pipid_regs.sv
// ----------------------------------------------------------------------------
// pipid_regs
// Configuration register file: mode, three gains and the integral clamp.
// ----------------------------------------------------------------------------
module pipid_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pipid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pipid_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pipid_pkg::pid_cfg_t            cfg_o
);
  import pipid_pkg::*;

  pid_cfg_t cfg_r;
  pid_cfg_t cfg_nxt;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:  cfg_nxt.mode  = pid_mode_t'(cfg_wdata[0]);
        REG_KP:    cfg_nxt.kp    = cfg_wdata[GAIN_W-1:0];
        REG_KI:    cfg_nxt.ki    = cfg_wdata[GAIN_W-1:0];
        REG_KD:    cfg_nxt.kd    = cfg_wdata[GAIN_W-1:0];
        REG_LIMIT: cfg_nxt.limit = cfg_wdata[LIMIT_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_POSITIONAL;
      cfg_r.kp    <= KP_RESET;
      cfg_r.ki    <= KI_RESET;
      cfg_r.kd    <= KD_RESET;
      cfg_r.limit <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

### design/pipid_core.sv
// ----------------------------------------------------------------------------
// pipid_core
// Input register, error history and integral state, and the three gain
// products registered for the output stage.
// ----------------------------------------------------------------------------
module pipid_core #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pipid_pkg::pid_cfg_t                cfg_i,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready_o,
  input  logic                               in_command,
  input  logic signed [DATA_WIDTH-1:0]       in_target,
  input  logic signed [DATA_WIDTH-1:0]       in_measured,
  // products toward the output stage
  output logic                               prod_valid_o,
  input  logic                               prod_ready_i,
  output logic signed [((DATA_WIDTH+3 > pipid_pkg::INTEG_W) ? DATA_WIDTH+3
                        : pipid_pkg::INTEG_W) + pipid_pkg::GAIN_W:0] prod_p_o,
  output logic signed [((DATA_WIDTH+3 > pipid_pkg::INTEG_W) ? DATA_WIDTH+3
                        : pipid_pkg::INTEG_W) + pipid_pkg::GAIN_W:0] prod_i_o,
  output logic signed [((DATA_WIDTH+3 > pipid_pkg::INTEG_W) ? DATA_WIDTH+3
                        : pipid_pkg::INTEG_W) + pipid_pkg::GAIN_W:0] prod_d_o
);
  import pipid_pkg::*;

  localparam int ERR_W  = DATA_WIDTH + 1;
  localparam int OPND_W = (DATA_WIDTH + 3 > INTEG_W) ? DATA_WIDTH + 3 : INTEG_W;
  localparam int PROD_W = OPND_W + GAIN_W + 1;
  localparam int ACC_W  = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;

  // input register
  logic                          in_valid_r;
  logic                          cmd_r;
  logic signed [DATA_WIDTH-1:0]  target_r;
  logic signed [DATA_WIDTH-1:0]  measured_r;

  // controller state
  logic signed [INTEG_W-1:0]     integ_r, integ_nxt;
  logic signed [ERR_W-1:0]       last_r, last_nxt;
  logic signed [ERR_W-1:0]       prev_r, prev_nxt;

  // product register
  logic                          prod_valid_r;
  logic signed [PROD_W-1:0]      prod_p_r, prod_i_r, prod_d_r;

  logic                          in_ready;
  logic                          step;
  logic signed [ERR_W-1:0]       err;
  logic signed [ERR_W:0]         diff1;
  logic signed [ERR_W+1:0]       diff2;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       lim_pos;
  logic signed [ACC_W-1:0]       lim_neg;
  logic signed [INTEG_W-1:0]     integ_upd;
  logic signed [OPND_W-1:0]      opnd_p, opnd_i, opnd_d;
  logic signed [GAIN_W:0]        kp_s, ki_s, kd_s;

  assign in_ready   = !in_valid_r || prod_ready_i;
  assign in_ready_o = in_ready;
  assign step       = in_valid_r && prod_ready_i;

  // input register transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r      <= in_command;
      target_r   <= in_target;
      measured_r <= in_measured;
    end
  end

  // error and its differences
  assign err   = ERR_W'(target_r) - ERR_W'(measured_r);
  assign diff1 = (ERR_W+1)'(err) - (ERR_W+1)'(last_r);
  assign diff2 = (ERR_W+2)'(err) - ((ERR_W+2)'(last_r) <<< 1) + (ERR_W+2)'(prev_r);

  // integral advance and symmetric clamp
  assign acc     = ACC_W'(integ_r) + ACC_W'(err);
  assign lim_pos = ACC_W'(cfg_i.limit);
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc > lim_pos) begin
      integ_upd = INTEG_W'(lim_pos);
    end else if (acc < lim_neg) begin
      integ_upd = INTEG_W'(lim_neg);
    end else begin
      integ_upd = INTEG_W'(acc);
    end
  end

  // state update per item
  always_comb begin
    integ_nxt = integ_r;
    last_nxt  = last_r;
    prev_nxt  = prev_r;
    if (step) begin
      if (cmd_r == CMD_CLEAR) begin
        integ_nxt = '0;
      end else if (cfg_i.mode == MODE_POSITIONAL) begin
        integ_nxt = integ_upd;
        last_nxt  = err;
      end else begin
        prev_nxt = last_r;
        last_nxt = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r  <= '0;
      prev_r  <= '0;
    end else begin
      integ_r <= integ_nxt;
      last_r  <= last_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // multiplier operands per mode
  always_comb begin
    if (cfg_i.mode == MODE_POSITIONAL) begin
      opnd_p = OPND_W'(err);
      opnd_i = OPND_W'(integ_upd);
      opnd_d = OPND_W'(diff1);
    end else begin
      opnd_p = OPND_W'(diff1);
      opnd_i = OPND_W'(err);
      opnd_d = OPND_W'(diff2);
    end
  end

  assign kp_s = {1'b0, cfg_i.kp};
  assign ki_s = {1'b0, cfg_i.ki};
  assign kd_s = {1'b0, cfg_i.kd};

  // product register, a clear leaves no item behind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (prod_ready_i) begin
      prod_valid_r <= step && (cmd_r == CMD_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prod_p_r <= opnd_p * kp_s;
      prod_i_r <= opnd_i * ki_s;
      prod_d_r <= opnd_d * kd_s;
    end
  end

  assign prod_valid_o = prod_valid_r;
  assign prod_p_o     = prod_p_r;
  assign prod_i_o     = prod_i_r;
  assign prod_d_o     = prod_d_r;

endmodule

### design/pipid_out.sv
// ----------------------------------------------------------------------------
// pipid_out
// Sums the gain products, drops the fraction bits by flooring, saturates
// to 32 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module pipid_out #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               prod_valid_i,
  output logic                               prod_ready_o,
  input  logic signed [((DATA_WIDTH+3 > pipid_pkg::INTEG_W) ? DATA_WIDTH+3
                        : pipid_pkg::INTEG_W) + pipid_pkg::GAIN_W:0] prod_p_i,
  input  logic signed [((DATA_WIDTH+3 > pipid_pkg::INTEG_W) ? DATA_WIDTH+3
                        : pipid_pkg::INTEG_W) + pipid_pkg::GAIN_W:0] prod_i_i,
  input  logic signed [((DATA_WIDTH+3 > pipid_pkg::INTEG_W) ? DATA_WIDTH+3
                        : pipid_pkg::INTEG_W) + pipid_pkg::GAIN_W:0] prod_d_i,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pipid_pkg::DRIVE_W-1:0] out_drive
);
  import pipid_pkg::*;

  localparam int OPND_W = (DATA_WIDTH + 3 > INTEG_W) ? DATA_WIDTH + 3 : INTEG_W;
  localparam int PROD_W = OPND_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic                       out_valid_r;
  logic signed [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    shifted;
  logic [SUM_W-DRIVE_W:0]     upper;
  logic                       fits;
  logic                       out_ready;

  assign out_ready    = !out_valid_r || !out_stall;
  assign prod_ready_o = out_ready;

  // sum, floor shift and saturation
  assign sum     = SUM_W'(prod_p_i) + SUM_W'(prod_i_i) + SUM_W'(prod_d_i);
  assign shifted = sum >>> GAIN_FRAC_BITS;
  assign upper   = shifted[SUM_W-1:DRIVE_W-1];
  assign fits    = (&upper) || !(|upper);

  always_comb begin
    if (fits) begin
      drive_nxt = shifted[DRIVE_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      drive_nxt = DRIVE_MIN;
    end else begin
      drive_nxt = DRIVE_MAX;
    end
  end

  // output register transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= prod_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid_i) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = drive_r;

endmodule

### design/positional_incremental_pid_top.sv
// ----------------------------------------------------------------------------
// positional_incremental_pid_top
// Discrete PID regulator, positional or incremental form, Q8.8 gains.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output side keeps up. An update's drive
// value passes from the input register through the gain product register
// to the output register. The integral and the error history are updated
// as an item leaves the input register, so consecutive items see each
// other's state with no bubble. A clear command zeroes the integral and
// produces no result. While a result waits on a stalled output the gain
// product stage holds as well, and the input stalls once the input
// register is occupied too. Configuration is to be written only while no
// item is in flight.
module positional_incremental_pid_top #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [DATA_WIDTH-1:0]         in_target,
  input  logic signed [DATA_WIDTH-1:0]         in_measured,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pipid_pkg::DRIVE_W-1:0] out_drive,
  // configuration port
  input  logic                                 cfg_wr_en,
  input  logic [pipid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pipid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pipid_pkg::*;

  localparam int OPND_W = (DATA_WIDTH + 3 > INTEG_W) ? DATA_WIDTH + 3 : INTEG_W;
  localparam int PROD_W = OPND_W + GAIN_W + 1;

  pid_cfg_t                  cfg;
  logic                      in_ready;
  logic                      prod_valid;
  logic                      prod_ready;
  logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;

  assign in_stall = !in_ready;

  // configuration registers
  pipid_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // error, state and products
  pipid_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_valid     (in_valid),
    .in_ready_o   (in_ready),
    .in_command   (in_command),
    .in_target    (in_target),
    .in_measured  (in_measured),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_p_o     (prod_p),
    .prod_i_o     (prod_i),
    .prod_d_o     (prod_d)
  );

  // sum, floor, saturate, output register
  pipid_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_p_i     (prod_p),
    .prod_i_i     (prod_i),
    .prod_d_i     (prod_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive    (out_drive)
  );

endmodule

### design/pipid_chk.sv
// ----------------------------------------------------------------------------
// pipid_chk
// Port-level checks of the PID regulator, bound to the top level.
// ----------------------------------------------------------------------------
module pipid_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_command,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [pipid_pkg::DRIVE_W-1:0] out_drive
);
  import pipid_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive))
    else $error("stalled result changed");

  // a free output side never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // an update transfer reaches the result port while the output side stays free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == CMD_UPDATE) ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("update result missing");

endmodule

bind positional_incremental_pid_top pipid_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_drive  (out_drive)
);

### bench/positional_incremental_pid_top_tb.sv
// ----------------------------------------------------------------------------
// positional_incremental_pid_top_tb
// Self-checking bench for the PID regulator. A driver and a stall generator
// work on the falling edge. A monitor on the rising edge mirrors the
// configuration and the regulator state, predicts the drive value of every
// accepted update and compares it with the result channel. Directed items
// cover extreme errors, clears in both modes, a lowered integral limit and
// zero or full gains. Random phases follow with varied settings, bursts of
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module positional_incremental_pid_top_tb;
  import pipid_pkg::*;

  localparam int DW            = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 230;

  typedef struct packed {
    command_t        command;
    logic [DW-1:0]   target;
    logic [DW-1:0]   measured;
  } pid_item_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  in_command  = CMD_UPDATE;
  logic signed [DW-1:0]  in_target   = '0;
  logic signed [DW-1:0]  in_measured = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  // stimulus store and bookkeeping
  pid_item_t                 pending_items[$];
  logic signed [DRIVE_W-1:0] drive_expected[$];
  int n_queued    = 0;
  int n_offered   = 0;
  int n_accepted  = 0;
  int n_clears    = 0;
  int n_checked   = 0;
  int n_settings  = 0;
  int errors      = 0;
  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_count  = 0;
  int quiet_count = 0;
  bit quiet        = 1'b0;
  bit hold_request = 1'b0;

  // mirrored registers and regulator state
  pid_cfg_t                  gains_q;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [DW:0]        err_recent;
  logic signed [DW:0]        err_prev;

  positional_incremental_pid_top #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_target  (in_target),
    .in_measured(in_measured),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_drive  (out_drive),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // advance the mirrored regulator by one item and queue an update's drive value
  function automatic void predict_drive(pid_item_t it);
    longint err, acc, lim, kp, ki, kd, last, prev, sum, y;
    if (it.command == CMD_CLEAR) begin
      integ_acc = '0;
      return;
    end
    err  = longint'($signed(it.target)) - longint'($signed(it.measured));
    kp   = longint'(gains_q.kp);
    ki   = longint'(gains_q.ki);
    kd   = longint'(gains_q.kd);
    last = longint'(err_recent);
    prev = longint'(err_prev);
    if (gains_q.mode == MODE_POSITIONAL) begin
      lim = longint'(gains_q.limit);
      acc = longint'(integ_acc) + err;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integ_acc = acc[INTEG_W-1:0];
      sum = kp * err + ki * acc + kd * (err - last);
    end else begin
      sum = kp * (err - last) + ki * err + kd * (err - 2 * last + prev);
      err_prev = err_recent;
    end
    err_recent = err[DW:0];
    // floor the fraction away, then saturate
    y = sum >>> GAIN_FRAC_BITS;
    if (y > longint'(DRIVE_MAX)) y = longint'(DRIVE_MAX);
    if (y < longint'($signed(DRIVE_MIN))) y = longint'($signed(DRIVE_MIN));
    drive_expected.push_back(y[DRIVE_W-1:0]);
  endfunction

  // monitor: result check, input transfers, register writes, watchdog
  always @(posedge clk) begin
    bit                        moved;
    logic signed [DRIVE_W-1:0] want;
    pid_item_t                 seen;
    moved = 1'b0;
    if (!rst_n) begin
      gains_q    = '{MODE_POSITIONAL, KP_RESET, KI_RESET, KD_RESET, LIMIT_RESET};
      integ_acc  = '0;
      err_recent = '0;
      err_prev   = '0;
      quiet_count = 0;
    end else begin
      // result transfer
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (drive_expected.size() == 0) begin
          errors++;
          $error("drive: no value expected, actual %0d", out_drive);
        end else begin
          want = drive_expected.pop_front();
          n_checked++;
          if (out_drive !== want) begin
            errors++;
            $error("drive mismatch: expected %0d, actual %0d", want, out_drive);
          end
        end
      end
      // input transfer
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_accepted++;
        seen.command  = command_t'(in_command);
        seen.target   = in_target;
        seen.measured = in_measured;
        if (seen.command == CMD_CLEAR) n_clears++;
        predict_drive(seen);
      end
      // register write, masked to width, unknown indexes dropped
      if (cfg_wr_en) begin
        moved = 1'b1;
        case (cfg_index)
          REG_MODE:  gains_q.mode  = pid_mode_t'(cfg_wdata[0]);
          REG_KP:    gains_q.kp    = cfg_wdata[GAIN_W-1:0];
          REG_KI:    gains_q.ki    = cfg_wdata[GAIN_W-1:0];
          REG_KD:    gains_q.kd    = cfg_wdata[GAIN_W-1:0];
          REG_LIMIT: gains_q.limit = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      quiet_count = moved ? 0 : quiet_count + 1;
      if (quiet_count >= WATCHDOG_MAX) begin
        $error("no transfer for %0d cycles", WATCHDOG_MAX);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // driver: offers the next item once the current one has been taken
  always @(negedge clk) begin
    pid_item_t nxt;
    if (n_offered == n_accepted) begin
      if (send_idle > 0) begin
        send_idle--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_valid    <= 1'b1;
        in_command  <= nxt.command;
        in_target   <= nxt.target;
        in_measured <= nxt.measured;
        n_offered++;
        if (!quiet && $urandom_range(0, 4) == 0) send_idle = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall: one long hold-off on request, otherwise random bursts
  always @(negedge clk) begin
    if (hold_request && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else if (recv_idle > 0) begin
      out_stall <= 1'b1;
      recv_idle--;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 5) == 0) recv_idle = $urandom_range(1, 9);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // program all registers; spare upper bits carry junk that must be masked
  task automatic program_regs(input pid_mode_t m, input logic [GAIN_W-1:0] kp,
                              input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                              input logic [LIMIT_W-1:0] lim);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_IDX_W-1:0]  stray;
    junk  = CFG_DATA_W'($urandom);
    stray = CFG_IDX_W'($urandom_range(REG_LIMIT + 1, (1 << CFG_IDX_W) - 1));
    write_reg(stray, CFG_DATA_W'($urandom));
    write_reg(REG_MODE, {junk[CFG_DATA_W-1:1], logic'(m)});
    write_reg(REG_KP, {junk[CFG_DATA_W-1:GAIN_W], kp});
    write_reg(REG_KI, {~junk[CFG_DATA_W-1:GAIN_W], ki});
    write_reg(REG_KD, {junk[CFG_DATA_W-1:GAIN_W], kd});
    write_reg(REG_LIMIT, lim);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // wait for every result, then let trailing clears leave the pipeline
  task automatic drain();
    while (n_accepted != n_queued || drive_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_item(input command_t c, input logic [DW-1:0] t, input logic [DW-1:0] m);
    pending_items.push_back('{c, t, m});
    n_queued++;
  endtask

  function automatic logic [DW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return {1'b0, {(DW-1){1'b1}}};
      1:       return {1'b1, {(DW-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // random item: mostly updates with small, tracking, extreme or wide errors
  task automatic queue_random_item();
    int t, m;
    if ($urandom_range(0, 99) < 8) begin
      queue_item(CMD_CLEAR, DW'($urandom), DW'($urandom));
      return;
    end
    case ($urandom_range(0, 3))
      0: queue_item(CMD_UPDATE, DW'($urandom), DW'($urandom));
      1: begin
        t = int'($signed(DW'($urandom)));
        m = t + int'($urandom_range(0, 600)) - 300;
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        queue_item(CMD_UPDATE, DW'(t), DW'(m));
      end
      2: queue_item(CMD_UPDATE, pick_extreme(), pick_extreme());
      default: queue_item(CMD_UPDATE, DW'(int'($urandom_range(0, 127)) - 64),
                          DW'(int'($urandom_range(0, 127)) - 64));
    endcase
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(0, 1023));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_W'($urandom_range(1, 5000));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  // stimulus sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset settings: extreme errors, clears, flooring of a small negative sum
    @(posedge clk);
    queue_item(CMD_UPDATE, 16'sd32767, -16'sd32768);
    queue_item(CMD_UPDATE, -16'sd32768, 16'sd32767);
    queue_item(CMD_UPDATE, '0, '0);
    queue_item(CMD_CLEAR, '0, '0);
    queue_item(CMD_UPDATE, -16'sd3, 16'sd2);
    queue_item(CMD_CLEAR, 16'sd32767, -16'sd32768);
    drain();

    // full gains and limit, integral grows well past the later limit
    program_regs(MODE_POSITIONAL, '1, '1, '1, '1);
    @(posedge clk);
    queue_item(CMD_UPDATE, 16'sd32767, -16'sd32768);
    queue_item(CMD_UPDATE, 16'sd32767, -16'sd32768);
    queue_item(CMD_UPDATE, -16'sd32768, 16'sd32767);
    drain();

    // incremental with a small limit, stored integral must stay untouched
    program_regs(MODE_INCREMENTAL, 16'd1, 16'd3, '1, 20'd10);
    @(posedge clk);
    queue_item(CMD_UPDATE, 16'sd100, '0);
    queue_item(CMD_UPDATE, -16'sd100, '0);
    queue_item(CMD_UPDATE, 16'sd5, 16'sd7);
    drain();

    // positional again: the lowered limit clamps only after the next addition
    program_regs(MODE_POSITIONAL, '0, 16'd256, '0, 20'd10);
    @(posedge clk);
    queue_item(CMD_UPDATE, '0, '0);
    queue_item(CMD_UPDATE, 16'sd1, '0);
    queue_item(CMD_CLEAR, '0, '0);
    queue_item(CMD_UPDATE, -16'sd1, '0);
    drain();

    // clear in incremental mode keeps the error history
    program_regs(MODE_INCREMENTAL, 16'd300, 16'd77, 16'd901, 20'd0);
    @(posedge clk);
    queue_item(CMD_CLEAR, '0, '0);
    queue_item(CMD_UPDATE, 16'sd7, -16'sd7);
    drain();

    // zero gains and zero limit
    program_regs(MODE_POSITIONAL, '0, '0, '0, '0);
    @(posedge clk);
    queue_item(CMD_UPDATE, 16'sd32767, -16'sd32768);
    queue_item(CMD_UPDATE, -16'sd32768, 16'sd32767);
    drain();

    // random phases with varied settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        program_regs(MODE_POSITIONAL, '1, '1, '1, '1);
      else if (p == 1)
        program_regs(MODE_INCREMENTAL, '1, '1, '1, '0);
      else
        program_regs(pid_mode_t'($urandom_range(0, 1)), pick_gain(), pick_gain(),
                     pick_gain(), pick_limit());
      @(posedge clk);
      // long output hold-off so the block fills and stalls its input
      if (p == 2) hold_request = 1'b1;
      // no idling in the final phase
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();
      drain();
    end

    $display("sent %0d items (%0d clears) under %0d register settings",
             n_accepted, n_clears, n_settings);
    $display("checked %0d drive values, %0d mismatches", n_checked, errors);
    if (drive_expected.size() != 0) begin
      errors++;
      $error("%0d drive values never arrived", drive_expected.size());
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/pipid_pkg.sv
design/pipid_regs.sv
design/pipid_core.sv
design/pipid_out.sv
design/positional_incremental_pid_top.sv
design/pipid_chk.sv
bench/positional_incremental_pid_top_tb.sv
